### design/sphs_pkg.sv
// Package for the seen-pair hash set: sizes, hash constant, status codes,
// back-end state type and the queue status struct.
// No dependencies; every other design file refers to it by scoped names.
package sphs_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned KeyW       = 32;
  localparam int unsigned CntW       = 11;

  localparam logic [KeyW-1:0] KeyMult        = 32'd2654435761;
  localparam logic [CntW-1:0] FillLimitReset = 11'd512;

  typedef logic [KeyW-1:0]  key_t;
  typedef logic [AddrW-1:0] addr_t;
  typedef logic [CntW-1:0]  cnt_t;

  typedef enum logic [1:0] {
    StatusSeen  = 2'd0,
    StatusNovel = 2'd1,
    StatusFull  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    BackClear,
    BackIdle,
    BackProbe
  } back_state_e;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

### design/seen_pair_hash_set_top.sv
// Top level of the seen-pair hash set: fill-limit register, front end,
// key queue and probe engine. Depends on sphs_pkg, sphs_front, sphs_queue
// and sphs_back.
//
//   channel   ports                                    transfer at edge when
//   -------   --------------------------------------   ---------------------
//   item in   start, busy, cmp_id_i, condition_value_i  start && !busy
//   config    cfg_we_i, cfg_wdata_i                     cfg_we_i
//   result    result_valid_o, status_o, entry_total_o   result_valid_o
//
// After reset the slot memory is cleared one slot per cycle, and busy
// stays high for the whole pass. An item passes through the hash
// register and then the queue head, from which the probe engine pops it.
// The engine then reads 1 to TableDepth slots, one per cycle through the
// single read port, and the item's result strobe follows in the next
// cycle. The probe engine takes a new item only after it has finished
// with the last one. The receiver cannot stall results. busy rises only
// during the clearing pass, or when the queue and the hash register are
// both full.
module seen_pair_hash_set_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] cmp_id_i,
  input  logic [31:0] condition_value_i,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [10:0] entry_total_o
);

  sphs_pkg::cnt_t          fill_limit_q;
  sphs_pkg::queue_status_t q_status;
  sphs_pkg::key_t          push_key;
  sphs_pkg::key_t          head_key;
  logic                    push;
  logic                    pop;
  logic                    clearing;

  // The fill limit is to be written only while the block is idle, which the
  // block does not enforce, so the probe engine may read it directly.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_limit_q <= sphs_pkg::FillLimitReset;
    end else if (cfg_we_i) begin
      fill_limit_q <= cfg_wdata_i;
    end
  end

  // The front end hashes each accepted pair into its key.
  sphs_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .cmp_id_i          (cmp_id_i),
    .condition_value_i (condition_value_i),
    .clearing_i        (clearing),
    .q_status_i        (q_status),
    .push_o            (push),
    .key_o             (push_key)
  );

  // The queue lets the front end keep taking items during a long probe.
  sphs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_key_i (push_key),
    .pop_i      (pop),
    .head_key_o (head_key),
    .status_o   (q_status)
  );

  // The probe engine owns the slot memory and the entry count.
  sphs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_status_i     (q_status),
    .head_key_i     (head_key),
    .pop_o          (pop),
    .fill_limit_i   (fill_limit_q),
    .clearing_o     (clearing),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .entry_total_o  (entry_total_o)
  );

endmodule

### design/sphs_front.sv
// Front end: takes items on the start/busy handshake, folds each pair into
// a 32-bit key and hands the key to the queue. Depends on sphs_pkg.
module sphs_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [31:0]            cmp_id_i,
  input  logic [31:0]            condition_value_i,
  input  logic                   clearing_i,
  input  sphs_pkg::queue_status_t q_status_i,
  output logic                   push_o,
  output sphs_pkg::key_t         key_o
);

  logic           vld_q, vld_d;
  sphs_pkg::key_t key_q;
  sphs_pkg::key_t prod;
  logic           accept;

  // Only the low 32 bits of the product matter.
  assign prod   = condition_value_i * sphs_pkg::KeyMult;
  assign busy   = clearing_i | (vld_q & q_status_i.full);
  assign accept = start & ~busy;
  assign push_o = vld_q & ~q_status_i.full;
  assign key_o  = key_q;
  assign vld_d  = accept | (vld_q & q_status_i.full);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q <= cmp_id_i ^ prod;
    end
  end

endmodule

### design/sphs_queue.sv
// Two-entry key queue between the front end and the probe engine.
// Depends on sphs_pkg.
module sphs_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  sphs_pkg::key_t          push_key_i,
  input  logic                    pop_i,
  output sphs_pkg::key_t          head_key_o,
  output sphs_pkg::queue_status_t status_o
);

  sphs_pkg::key_t entry_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     fill_q, fill_d;

  assign status_o.full  = (fill_q == 2'd2);
  assign status_o.empty = (fill_q == 2'd0);
  assign head_key_o     = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    fill_d   = fill_q;
    if (push_i && !pop_i) begin
      fill_d = fill_q + 2'd1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_key_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && status_o.full))
    else $error("queue pushed while full");

endmodule

### design/sphs_back.sv
// Back end: clears the slot memory after reset, then probes it linearly for
// each queued key, stores novel keys while below the fill limit and drives
// the result strobe. Depends on sphs_pkg.
module sphs_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sphs_pkg::queue_status_t q_status_i,
  input  sphs_pkg::key_t          head_key_i,
  output logic                    pop_o,
  input  sphs_pkg::cnt_t          fill_limit_i,
  output logic                    clearing_o,
  output logic                    result_valid_o,
  output logic [1:0]              status_o,
  output logic [10:0]             entry_total_o
);

  // Each slot holds a valid bit above the key.
  logic [sphs_pkg::KeyW:0] mem [sphs_pkg::TableDepth];
  logic [sphs_pkg::KeyW:0] rd_q;

  sphs_pkg::back_state_e state_q, state_d;
  sphs_pkg::addr_t       pos_q, pos_d;
  sphs_pkg::addr_t       probe_q, probe_d;
  sphs_pkg::addr_t       clr_q, clr_d;
  sphs_pkg::key_t        key_q, key_d;
  sphs_pkg::cnt_t        count_q, count_d;

  logic                    rd_en;
  sphs_pkg::addr_t         rd_addr;
  logic                    we;
  sphs_pkg::addr_t         wr_addr;
  logic [sphs_pkg::KeyW:0] wr_data;

  logic             res_vld_q, res_vld_d;
  sphs_pkg::status_e res_status_q, res_status_d;
  sphs_pkg::cnt_t   res_total_q, res_total_d;

  logic hit_empty, hit_match, last_slot, finish;

  assign hit_empty = ~rd_q[sphs_pkg::KeyW];
  assign hit_match = rd_q[sphs_pkg::KeyW] & (rd_q[sphs_pkg::KeyW-1:0] == key_q);
  assign last_slot = (probe_q == {sphs_pkg::AddrW{1'b1}});
  assign finish    = hit_empty | hit_match | last_slot;

  always_comb begin
    state_d = state_q;
    case (state_q)
      sphs_pkg::BackClear: begin
        if (clr_q == {sphs_pkg::AddrW{1'b1}}) begin
          state_d = sphs_pkg::BackIdle;
        end
      end
      sphs_pkg::BackIdle: begin
        if (!q_status_i.empty) begin
          state_d = sphs_pkg::BackProbe;
        end
      end
      sphs_pkg::BackProbe: begin
        if (finish) begin
          state_d = sphs_pkg::BackIdle;
        end
      end
      default: state_d = sphs_pkg::BackClear;
    endcase
  end

  always_comb begin
    pop_o        = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = pos_q;
    we           = 1'b0;
    wr_addr      = pos_q;
    wr_data      = {1'b1, key_q};
    pos_d        = pos_q;
    probe_d      = probe_q;
    clr_d        = clr_q;
    key_d        = key_q;
    count_d      = count_q;
    res_vld_d    = 1'b0;
    res_status_d = res_status_q;
    res_total_d  = res_total_q;
    case (state_q)
      sphs_pkg::BackClear: begin
        we      = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
        clr_d   = clr_q + 1'b1;
      end
      sphs_pkg::BackIdle: begin
        if (!q_status_i.empty) begin
          pop_o   = 1'b1;
          key_d   = head_key_i;
          pos_d   = head_key_i[sphs_pkg::AddrW-1:0];
          probe_d = '0;
          rd_en   = 1'b1;
          rd_addr = head_key_i[sphs_pkg::AddrW-1:0];
        end
      end
      sphs_pkg::BackProbe: begin
        if (hit_empty) begin
          res_vld_d = 1'b1;
          if (count_q < fill_limit_i) begin
            we           = 1'b1;
            count_d      = count_q + 1'b1;
            res_status_d = sphs_pkg::StatusNovel;
            res_total_d  = count_q + 1'b1;
          end else begin
            res_status_d = sphs_pkg::StatusFull;
            res_total_d  = count_q;
          end
        end else if (hit_match) begin
          res_vld_d    = 1'b1;
          res_status_d = sphs_pkg::StatusSeen;
          res_total_d  = count_q;
        end else if (last_slot) begin
          res_vld_d    = 1'b1;
          res_status_d = sphs_pkg::StatusFull;
          res_total_d  = count_q;
        end else begin
          pos_d   = pos_q + 1'b1;
          probe_d = probe_q + 1'b1;
          rd_en   = 1'b1;
          rd_addr = pos_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sphs_pkg::BackClear;
      clr_q     <= '0;
      count_q   <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      count_q   <= count_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    probe_q      <= probe_d;
    key_q        <= key_d;
    res_status_q <= res_status_d;
    res_total_q  <= res_total_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign clearing_o     = (state_q == sphs_pkg::BackClear);
  assign result_valid_o = res_vld_q;
  assign status_o       = res_status_q;
  assign entry_total_o  = res_total_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |=> !res_vld_q)
    else $error("result strobe longer than one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sphs_pkg::BackProbe && we) |-> (!rd_q[sphs_pkg::KeyW] && !pop_o))
    else $error("key stored over an occupied slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sphs_pkg::BackClear) |=> !res_vld_q)
    else $error("result produced during the clearing pass");

endmodule

### verif/seen_pair_hash_set_checker.sv
// Checker for the seen-pair hash set: watches the item, configuration and
// result channels, keeps its own copy of the slot table and compares results.
// Depends on sphs_pkg for sizes, the hash constant and the status codes.
module seen_pair_hash_set_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_start_i,
  input  logic                 item_busy_i,
  input  logic [31:0]          item_id_i,
  input  logic [31:0]          item_cond_i,
  input  logic                 cfg_we_i,
  input  logic [10:0]          cfg_wdata_i,
  input  logic                 res_valid_i,
  input  logic [1:0]           res_status_i,
  input  logic [10:0]          res_total_i,
  output int unsigned          fail_count_o = 0,
  output int unsigned          pending_o = 0
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    sphs_pkg::status_e status;
    sphs_pkg::cnt_t    total;
  } outcome_t;

  sphs_pkg::key_t stored_key [sphs_pkg::TableDepth];
  logic           occupied   [sphs_pkg::TableDepth];
  sphs_pkg::cnt_t entry_count;
  sphs_pkg::cnt_t fill_limit;
  outcome_t       expected_outcomes [$];

  // Linear probe from the home slot; stops at a matching key or a free slot.
  function automatic outcome_t look_up_pair(logic [31:0] id, logic [31:0] cond);
    sphs_pkg::key_t  key;
    sphs_pkg::addr_t slot;
    bit              hit;
    bit              open;
    outcome_t        outcome;
    key = id ^ (cond * sphs_pkg::KeyMult);
    slot = key[sphs_pkg::AddrW-1:0];
    hit = 1'b0;
    open = 1'b0;
    for (int unsigned n = 0; n < sphs_pkg::TableDepth; n++) begin
      if (!occupied[slot]) begin
        open = 1'b1;
        break;
      end
      if (stored_key[slot] == key) begin
        hit = 1'b1;
        break;
      end
      slot = slot + 1'b1;
    end
    if (hit) begin
      outcome.status = sphs_pkg::StatusSeen;
    end else if (open && entry_count < fill_limit) begin
      stored_key[slot] = key;
      occupied[slot] = 1'b1;
      entry_count = entry_count + 1'b1;
      outcome.status = sphs_pkg::StatusNovel;
    end else begin
      outcome.status = sphs_pkg::StatusFull;
    end
    outcome.total = entry_count;
    return outcome;
  endfunction

  task automatic record_failure(string msg);
    fail_count_o++;
    if (fail_count_o <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    outcome_t want;
    if (!rst_ni) begin
      for (int s = 0; s < sphs_pkg::TableDepth; s++) begin
        occupied[s] = 1'b0;
      end
      entry_count = '0;
      fill_limit = sphs_pkg::FillLimitReset;
      expected_outcomes.delete();
      pending_o <= 0;
    end else begin
      // A result always belongs to an item accepted at an earlier edge.
      if (res_valid_i === 1'b1) begin
        if (expected_outcomes.size() == 0) begin
          record_failure($sformatf("result status=%0d total=%0d with none expected",
                                   res_status_i, res_total_i));
        end else begin
          want = expected_outcomes.pop_front();
          if (res_status_i !== want.status || res_total_i !== want.total) begin
            record_failure($sformatf("expected status=%0d total=%0d, got status=%0d total=%0d",
                                     want.status, want.total, res_status_i, res_total_i));
          end
        end
      end
      if (cfg_we_i === 1'b1) begin
        fill_limit = cfg_wdata_i;
      end
      if (item_start_i === 1'b1 && item_busy_i === 1'b0) begin
        expected_outcomes.push_back(look_up_pair(item_id_i, item_cond_i));
      end
      pending_o <= expected_outcomes.size();
    end
  end

endmodule

### verif/tb_seen_pair_hash_set_top.sv
// Testbench top for the seen-pair hash set: clock, reset, item and fill-limit
// stimulus, and the final verdict. Depends on sphs_pkg, seen_pair_hash_set_top
// and seen_pair_hash_set_checker, which does all prediction and comparison.
module tb_seen_pair_hash_set_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] id;
    logic [31:0] cond;
  } pair_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] cmp_id_i = '0;
  logic [31:0] condition_value_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [10:0] cfg_wdata_i = '0;
  logic        result_valid_o;
  logic [1:0]  status_o;
  logic [10:0] entry_total_o;

  int unsigned fail_count;
  int unsigned pending;

  // Recently sent pairs, so that the random part can replay them and hit
  // the already-seen path often.
  pair_t sent_pairs [$];
  bit    gaps_on = 1'b1;

  seen_pair_hash_set_top u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .cmp_id_i          (cmp_id_i),
    .condition_value_i (condition_value_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .result_valid_o    (result_valid_o),
    .status_o          (status_o),
    .entry_total_o     (entry_total_o)
  );

  seen_pair_hash_set_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_start_i (start),
    .item_busy_i  (busy),
    .item_id_i    (cmp_id_i),
    .item_cond_i  (condition_value_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .res_valid_i  (result_valid_o),
    .res_status_i (status_o),
    .res_total_i  (entry_total_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 12 ns clock period.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Hard stop. This bound covers the run several times over even if every
  // item probed the whole table after the longest gap.
  initial begin
    #40_000_000;
    $display("FAIL seen_pair_hash_set_top");
    $finish;
  end

  // Mostly back-to-back transfers, some short gaps and a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (!gaps_on || roll < 65) begin
      return 0;
    end else if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Offers one pair and holds it until the block takes it. start stays high
  // when no gap follows, so that the next pair can go in on the next edge.
  task automatic send_pair(input logic [31:0] id, input logic [31:0] cond);
    int unsigned gap;
    pair_t       sent;
    sent.id = id;
    sent.cond = cond;
    start <= 1'b1;
    cmp_id_i <= id;
    condition_value_i <= cond;
    do @(posedge clk_i); while (busy);
    if (sent_pairs.size() >= 256) begin
      void'(sent_pairs.pop_front());
    end
    sent_pairs.push_back(sent);
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stops sending and waits for every outstanding result. The first edge lets
  // the checker's count take in a transfer made at the current edge.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Only called with the block idle; every item yields a result, so an empty
  // expectation queue means nothing is still in flight.
  task automatic write_limit(input logic [10:0] value);
    cfg_wdata_i <= value;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random traffic: replays of earlier pairs, other pairs that fold to an
  // already used key, pairs that crowd a few home slots, and fresh values.
  task automatic send_random_pair();
    int unsigned roll;
    pair_t       old;
    logic [31:0] key;
    logic [31:0] cond;
    logic [31:0] id;
    roll = $urandom_range(99);
    if (sent_pairs.size() != 0) begin
      old = sent_pairs[$urandom_range(sent_pairs.size() - 1)];
    end else begin
      roll = 99;
    end
    if (roll < 35) begin
      send_pair(old.id, old.cond);
    end else if (roll < 50) begin
      key = old.id ^ (old.cond * sphs_pkg::KeyMult);
      cond = $urandom;
      id = key ^ (cond * sphs_pkg::KeyMult);
      send_pair(id, cond);
    end else if (roll < 60) begin
      id = $urandom;
      id[sphs_pkg::AddrW-1:0] = sphs_pkg::addr_t'($urandom_range(7));
      send_pair(id, 32'd0);
    end else begin
      send_pair($urandom, $urandom);
    end
  endtask

  initial begin : stimulus
    logic [10:0] limit;
    do @(posedge clk_i); while (0);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, reset fill limit. The first transfer waits out the
    // clearing pass through busy.
    send_pair(32'h0000_0000, 32'h0000_0000);
    send_pair(32'h0000_0000, 32'h0000_0000);
    // A key of all ones lands in the last slot and is stored like any other.
    send_pair(32'hFFFF_FFFF, 32'h0000_0000);
    send_pair(32'hFFFF_FFFF, 32'h0000_0000);
    send_pair(32'h0000_0000, 32'hFFFF_FFFF);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Keys that share home slot 0 push each other further along.
    send_pair(32'd1024, 32'd0);
    send_pair(32'd2048, 32'd0);
    // Home slot is the last one, which is taken, so the probe wraps around.
    send_pair(32'd2047, 32'd0);
    send_pair(32'd2048, 32'd0);
    // A different pair that folds to key zero is reported as already seen.
    send_pair(sphs_pkg::KeyMult, 32'd1);
    send_pair(32'h8000_0000, 32'h8000_0000);
    drain();

    // Entry count already above the limit: novel pairs are refused.
    write_limit(11'd1);
    send_pair(32'd12345, 32'd678);
    send_pair(32'd1024, 32'd0);
    drain();
    write_limit(11'd0);
    send_pair(32'd1, 32'd1);
    send_pair(32'h0000_0000, 32'hFFFF_FFFF);
    drain();

    // Random part in four phases with different limits. The table stays at
    // most about 60 percent full, so probes stay short. Phase 1 runs with
    // no gaps, and phase 2 pauses halfway until all results are back.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: limit = 11'd300;
        1: limit = 11'd150;
        2: limit = 11'd520;
        default: limit = 11'($urandom_range(1, 600));
      endcase
      write_limit(limit);
      gaps_on = (phase != 1);
      for (int n = 0; n < 200; n++) begin
        if (phase == 2 && n == 100) begin
          drain();
        end
        send_random_pair();
      end
      drain();
    end

    // Limit at its top value: novel keys are stored again, and pairs sent
    // before are still reported as seen.
    write_limit(11'h7FF);
    gaps_on = 1'b1;
    repeat (8) send_pair($urandom, $urandom);
    send_pair(32'd5, 32'd0);
    send_pair(32'h0000_0000, 32'h0000_0000);
    drain();

    // Quiet tail so a stray result after the last one is still caught.
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS seen_pair_hash_set_top");
    end else begin
      $display("FAIL seen_pair_hash_set_top");
    end
    $finish;
  end

endmodule
